/* rtl/jsu_pkg.sv */
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  typedef enum logic [1:0] {
    OP_TEXT  = 2'd0,
    OP_END   = 2'd1,
    OP_START = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_CLOSE = 2'd1,
    ST_ERR   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_UNTERM_STR  = 4'd1,
    ERR_UNTERM_ESC  = 4'd2,
    ERR_UNKNOWN_ESC = 4'd3,
    ERR_NON_HEX     = 4'd4,
    ERR_TRUNC_U     = 4'd5,
    ERR_MISSING_U   = 4'd6,
    ERR_NOT_LOW     = 4'd7,
    ERR_LONE_LOW    = 4'd8,
    ERR_CTRL        = 4'd9
  } err_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_STR    = 4'd1,
    PH_ESC    = 4'd2,
    PH_HEX1   = 4'd3,
    PH_NEEDBS = 4'd4,
    PH_NEEDU  = 4'd5,
    PH_HEX2   = 4'd6
  } phase_e;

  typedef enum logic [1:0] {
    JOB_BYTE  = 2'd0,
    JOB_UTF8  = 2'd1,
    JOB_CLOSE = 2'd2,
    JOB_ERR   = 2'd3
  } job_kind_e;

  localparam int unsigned CodeW = 21;

  // Work handed from the front to the back: one job gives one to four results.
  typedef struct packed {
    job_kind_e          kind;
    logic [CodeW-1:0]   code;   // code point, or the raw byte in the low bits
    err_e               err;
  } job_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] text_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic [3:0] error_code;
    logic       last;
  } out_rsp_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;
  localparam int unsigned QCw    = 3;

  localparam logic [5:0]       SurrHiTag = 6'b110110;
  localparam logic [5:0]       SurrLoTag = 6'b110111;
  localparam logic [CodeW-1:0] PairBase  = 21'h10000;

endpackage

/* rtl/jsu_fifo.sv */
// Short job queue between the front and the back, held in flops.
module jsu_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::job_t push_job_i,
  input  logic          pop_i,
  output jsu_pkg::job_t head_o,
  output logic          empty_o,
  output logic          full_o
);
  import jsu_pkg::*;

  job_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCw-1:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCw'(QDepth));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("job queue underflow");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCw'(QDepth)) else $error("job queue count out of range");

endmodule

/* rtl/jsu_front.sv */
// Front end: accepts requests, runs the escape state machine, queues jobs.
module jsu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  jsu_pkg::in_req_t req_i,
  output logic             push_o,
  output jsu_pkg::job_t    job_o
);
  import jsu_pkg::*;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] CtrlLim  = 8'h20;

  phase_e      phase_q, phase_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] accum_q, accum_d;
  logic [9:0]  high_q, high_d;

  opcode_e     op;
  logic [7:0]  c;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] new_code;
  logic        hex_done;
  logic        is_hi, is_lo;

  assign op = opcode_e'(req_i.opcode);
  assign c  = req_i.text_byte;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign new_code = {accum_q[11:0], hex_val};
  assign hex_done = (hex_cnt_q == 2'd3);
  assign is_hi    = (new_code[15:10] == SurrHiTag);
  assign is_lo    = (new_code[15:10] == SurrLoTag);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      unique case (op)
        OP_START: phase_d = PH_STR;
        OP_END:   phase_d = PH_IDLE;
        OP_RSVD:  phase_d = phase_q;
        OP_TEXT: begin
          unique case (phase_q)
            PH_STR: begin
              if (c == ChQuote || c < CtrlLim) begin
                phase_d = PH_IDLE;
              end else if (c == ChBslash) begin
                phase_d = PH_ESC;
              end
            end
            PH_ESC: begin
              unique case (c)
                ChQuote, ChBslash, ChSlash, ChLowB, ChLowF, ChLowN, ChLowR, ChLowT:
                  phase_d = PH_STR;
                ChLowU:  phase_d = PH_HEX1;
                default: phase_d = PH_IDLE;
              endcase
            end
            PH_HEX1: begin
              if (!hex_ok) begin
                phase_d = PH_IDLE;
              end else if (hex_done) begin
                phase_d = is_hi ? PH_NEEDBS : (is_lo ? PH_IDLE : PH_STR);
              end
            end
            PH_HEX2: begin
              if (!hex_ok) begin
                phase_d = PH_IDLE;
              end else if (hex_done) begin
                phase_d = is_lo ? PH_STR : PH_IDLE;
              end
            end
            PH_NEEDBS: phase_d = (c == ChBslash) ? PH_NEEDU : PH_IDLE;
            PH_NEEDU:  phase_d = (c == ChLowU) ? PH_HEX2 : PH_IDLE;
            default:   phase_d = PH_IDLE;
          endcase
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  // Job and datapath registers
  always_comb begin
    push_o     = 1'b0;
    job_o.kind = JOB_BYTE;
    job_o.code = '0;
    job_o.err  = ERR_NONE;
    hex_cnt_d  = hex_cnt_q;
    accum_d    = accum_q;
    high_d     = high_q;
    if (accept_i) begin
      unique case (op)
        OP_START: begin
          hex_cnt_d = '0;
          accum_d   = '0;
          high_d    = '0;
        end
        OP_RSVD: ;
        OP_END: begin
          job_o.kind = JOB_ERR;
          push_o     = 1'b1;
          unique case (phase_q)
            PH_STR:             job_o.err = ERR_UNTERM_STR;
            PH_ESC:             job_o.err = ERR_UNTERM_ESC;
            PH_HEX1, PH_HEX2:   job_o.err = ERR_TRUNC_U;
            PH_NEEDBS, PH_NEEDU: job_o.err = ERR_MISSING_U;
            default:            push_o = 1'b0;
          endcase
        end
        OP_TEXT: begin
          unique case (phase_q)
            PH_STR: begin
              if (c == ChQuote) begin
                push_o     = 1'b1;
                job_o.kind = JOB_CLOSE;
              end else if (c == ChBslash) begin
                push_o = 1'b0;
              end else if (c < CtrlLim) begin
                push_o     = 1'b1;
                job_o.kind = JOB_ERR;
                job_o.err  = ERR_CTRL;
              end else begin
                push_o     = 1'b1;
                job_o.code = CodeW'(c);
              end
            end
            PH_ESC: begin
              push_o = 1'b1;
              unique case (c)
                ChQuote, ChBslash, ChSlash: job_o.code = CodeW'(c);
                ChLowB: job_o.code = CodeW'(8'h08);
                ChLowF: job_o.code = CodeW'(8'h0C);
                ChLowN: job_o.code = CodeW'(8'h0A);
                ChLowR: job_o.code = CodeW'(8'h0D);
                ChLowT: job_o.code = CodeW'(8'h09);
                ChLowU: begin
                  push_o    = 1'b0;
                  hex_cnt_d = '0;
                  accum_d   = '0;
                end
                default: begin
                  job_o.kind = JOB_ERR;
                  job_o.err  = ERR_UNKNOWN_ESC;
                end
              endcase
            end
            PH_HEX1, PH_HEX2: begin
              if (!hex_ok) begin
                push_o     = 1'b1;
                job_o.kind = JOB_ERR;
                job_o.err  = ERR_NON_HEX;
              end else begin
                accum_d   = new_code;
                hex_cnt_d = hex_cnt_q + 1'b1;   // wraps to zero after the fourth digit
                if (hex_done) begin
                  push_o     = 1'b1;
                  job_o.kind = JOB_UTF8;
                  if (phase_q == PH_HEX1) begin
                    job_o.code = CodeW'(new_code);
                    if (is_hi) begin
                      push_o = 1'b0;
                      high_d = new_code[9:0];
                    end else if (is_lo) begin
                      job_o.kind = JOB_ERR;
                      job_o.err  = ERR_LONE_LOW;
                    end
                  end else begin
                    job_o.code = {1'b0, high_q, new_code[9:0]} + PairBase;
                    if (!is_lo) begin
                      job_o.kind = JOB_ERR;
                      job_o.err  = ERR_NOT_LOW;
                    end
                  end
                end
              end
            end
            PH_NEEDBS: begin
              if (c != ChBslash) begin
                push_o     = 1'b1;
                job_o.kind = JOB_ERR;
                job_o.err  = ERR_MISSING_U;
              end
            end
            PH_NEEDU: begin
              if (c != ChLowU) begin
                push_o     = 1'b1;
                job_o.kind = JOB_ERR;
                job_o.err  = ERR_MISSING_U;
              end else begin
                hex_cnt_d = '0;
                accum_d   = '0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hex_cnt_q <= '0;
      accum_q   <= '0;
      high_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      hex_cnt_q <= hex_cnt_d;
      accum_q   <= accum_d;
      high_q    <= high_d;
    end
  end

  a_err_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && job_o.kind == JOB_ERR |=> phase_q == PH_IDLE)
    else $error("front not idle after error");
  a_hex_count_only_in_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_cnt_q != 2'd0 |-> phase_q == PH_HEX1 || phase_q == PH_HEX2 || phase_q == PH_IDLE)
    else $error("hex digit count outside a unicode escape");
  a_push_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept_i)
    else $error("job queued without an accepted request");

endmodule

/* rtl/jsu_back.sv */
// Back end: expands queued jobs into result items through an output register.
module jsu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jsu_pkg::job_t     head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output jsu_pkg::out_rsp_t out_rsp_o
);
  import jsu_pkg::*;

  logic       out_valid_q, out_valid_d;
  out_rsp_t   out_q, out_d;
  logic [1:0] idx_q, idx_d;

  logic [CodeW-1:0] code;
  logic [1:0]       len_m1;
  logic [1:0]       remain;
  logic             load;
  logic             res_last;
  logic [5:0]       chunk;

  assign code = head_i.code;

  always_comb begin
    if (code[20:16] != '0) begin
      len_m1 = 2'd3;
    end else if (code[15:11] != '0) begin
      len_m1 = 2'd2;
    end else if (code[10:7] != '0) begin
      len_m1 = 2'd1;
    end else begin
      len_m1 = 2'd0;
    end
  end

  assign remain = len_m1 - idx_q;

  always_comb begin
    unique case (remain)
      2'd0: chunk = code[5:0];
      2'd1: chunk = code[11:6];
      2'd2: chunk = code[17:12];
      2'd3: chunk = {3'b000, code[20:18]};
      default: chunk = '0;
    endcase
  end

  // Result for the current position of the head job
  always_comb begin
    out_d.data_byte  = '0;
    out_d.status     = ST_DATA;
    out_d.error_code = ERR_NONE;
    res_last         = 1'b1;
    unique case (head_i.kind)
      JOB_BYTE:  out_d.data_byte = code[7:0];
      JOB_CLOSE: out_d.status = ST_CLOSE;
      JOB_ERR: begin
        out_d.status     = ST_ERR;
        out_d.error_code = head_i.err;
      end
      JOB_UTF8: begin
        res_last = (remain == 2'd0);
        if (idx_q != 2'd0) begin
          out_d.data_byte = {2'b10, chunk};
        end else begin
          unique case (len_m1)
            2'd0: out_d.data_byte = {1'b0, code[6:0]};
            2'd1: out_d.data_byte = {3'b110, code[10:6]};
            2'd2: out_d.data_byte = {4'b1110, code[15:12]};
            2'd3: out_d.data_byte = {5'b11110, code[20:18]};
            default: out_d.data_byte = '0;
          endcase
        end
      end
      default: ;
    endcase
    out_d.last = res_last;
  end

  assign load  = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && res_last;

  always_comb begin
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = res_last ? 2'd0 : idx_q + 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_mid_job_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> !empty_i) else $error("queue emptied in the middle of a job");
  a_nondata_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_DATA |-> out_rsp_o.last)
    else $error("close or error result not marked last");
  a_utf8_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i && head_i.kind == JOB_UTF8 |-> idx_q <= len_m1)
    else $error("UTF-8 byte index past sequence length");

endmodule

/* rtl/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper with UTF-8 output.
//
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_ready_o    | in_req_i  (opcode, text_byte)
//  out     | output    | out_valid_o / out_ready_i  | out_rsp_o (data_byte, status,
//          |           |                            |   error_code, last)
//
// One request per cycle is taken while the job queue has room; each request is
// decoded combinationally by the front state machine as it is accepted.
// The back end delivers one result per cycle while out_ready_i is high: a job
// gives one to four results, so a code point above 0x7F holds the queue head
// until its last byte is loaded. Results pass the job queue, then the output register.
// Reset returns to idle (ignoring bytes) with the queue and output register empty.
// A stalled output fills the four-entry queue, after which in_ready_o drops.
module json_string_unescape_utf8 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  jsu_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output jsu_pkg::out_rsp_t out_rsp_o
);
  import jsu_pkg::*;

  logic q_full, q_empty, q_push, q_pop;
  job_t push_job, head_job;
  logic accept;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && !q_full;

  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_req_i),
    .push_o   (q_push),
    .job_o    (push_job)
  );

  jsu_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .pop_i      (q_pop),
    .head_o     (head_job),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the JSON string unescaper: scoreboard, stimulus and flow control.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam int HoldoffCycles = 80;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  out_rsp_t out_rsp_o;

  json_string_unescape_utf8 uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  in_req_t  byte_stream_q[$];
  out_rsp_t utf8_expect_q[$];
  out_rsp_t step_res[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  holdoff_on = 1'b0;
  int  holdoff_cycles = 0;
  int  items_queued = 0;
  int  requests_taken = 0;
  int  backpressure_cycles = 0;
  int  mismatches = 0;
  int  results_seen = 0;
  int  n_data = 0;
  int  n_close = 0;
  int  n_err = 0;
  bit  [15:0] err_kinds_seen = '0;

  // Decoder state of the predictor
  phase_e      dec_phase = PH_IDLE;
  logic [1:0]  dec_hex_n = '0;
  logic [15:0] dec_accum = '0;
  logic [9:0]  dec_high = '0;

  function automatic void emit(logic [7:0] b, status_e st, err_e e);
    out_rsp_t r;
    r.data_byte  = b;
    r.status     = st;
    r.error_code = e;
    r.last       = 1'b0;
    step_res = {step_res, r};
  endfunction

  function automatic void reject(err_e e);
    dec_phase = PH_IDLE;
    emit(8'h00, ST_ERR, e);
  endfunction

  function automatic void emit_utf8(logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(cp[7:0], ST_DATA, ERR_NONE);
    end else if (cp < 21'h800) begin
      emit({3'b110, cp[10:6]}, ST_DATA, ERR_NONE);
      emit({2'b10, cp[5:0]}, ST_DATA, ERR_NONE);
    end else if (cp < 21'h10000) begin
      emit({4'b1110, cp[15:12]}, ST_DATA, ERR_NONE);
      emit({2'b10, cp[11:6]}, ST_DATA, ERR_NONE);
      emit({2'b10, cp[5:0]}, ST_DATA, ERR_NONE);
    end else begin
      emit({5'b11110, cp[20:18]}, ST_DATA, ERR_NONE);
      emit({2'b10, cp[17:12]}, ST_DATA, ERR_NONE);
      emit({2'b10, cp[11:6]}, ST_DATA, ERR_NONE);
      emit({2'b10, cp[5:0]}, ST_DATA, ERR_NONE);
    end
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void decode_text(logic [7:0] c);
    int d;
    logic [15:0] code;
    case (dec_phase)
      PH_STR: begin
        if (c == CH_QUOTE) begin
          dec_phase = PH_IDLE;
          emit(8'h00, ST_CLOSE, ERR_NONE);
        end else if (c == CH_BSLASH) begin
          dec_phase = PH_ESC;
        end else if (c < 8'h20) begin
          reject(ERR_CTRL);
        end else begin
          emit(c, ST_DATA, ERR_NONE);
        end
      end
      PH_ESC: begin
        dec_phase = PH_STR;
        case (c)
          CH_QUOTE:  emit(CH_QUOTE, ST_DATA, ERR_NONE);
          CH_BSLASH: emit(CH_BSLASH, ST_DATA, ERR_NONE);
          "/":       emit(8'h2F, ST_DATA, ERR_NONE);
          "b":       emit(8'h08, ST_DATA, ERR_NONE);
          "f":       emit(8'h0C, ST_DATA, ERR_NONE);
          "n":       emit(8'h0A, ST_DATA, ERR_NONE);
          "r":       emit(8'h0D, ST_DATA, ERR_NONE);
          "t":       emit(8'h09, ST_DATA, ERR_NONE);
          CH_U: begin
            dec_phase = PH_HEX1;
            dec_hex_n = '0;
            dec_accum = '0;
          end
          default: reject(ERR_UNKNOWN_ESC);
        endcase
      end
      PH_HEX1, PH_HEX2: begin
        d = hex_nibble(c);
        if (d < 0) begin
          reject(ERR_NON_HEX);
        end else begin
          dec_accum = {dec_accum[11:0], d[3:0]};
          if (dec_hex_n < 2'd3) begin
            dec_hex_n++;
          end else begin
            dec_hex_n = '0;
            code = dec_accum;
            if (dec_phase == PH_HEX1) begin
              if (code >= 16'hD800 && code <= 16'hDBFF) begin
                dec_high  = code[9:0];
                dec_phase = PH_NEEDBS;
              end else if (code >= 16'hDC00 && code <= 16'hDFFF) begin
                reject(ERR_LONE_LOW);
              end else begin
                dec_phase = PH_STR;
                emit_utf8({5'd0, code});
              end
            end else if (code < 16'hDC00 || code > 16'hDFFF) begin
              reject(ERR_NOT_LOW);
            end else begin
              dec_phase = PH_STR;
              emit_utf8(21'h10000 + {1'b0, dec_high, code[9:0]});
            end
          end
        end
      end
      PH_NEEDBS: begin
        if (c != CH_BSLASH) reject(ERR_MISSING_U);
        else dec_phase = PH_NEEDU;
      end
      PH_NEEDU: begin
        if (c != CH_U) begin
          reject(ERR_MISSING_U);
        end else begin
          dec_phase = PH_HEX2;
          dec_hex_n = '0;
          dec_accum = '0;
        end
      end
      default: dec_phase = PH_IDLE;
    endcase
  endfunction

  function automatic void decode_end();
    case (dec_phase)
      PH_STR:              reject(ERR_UNTERM_STR);
      PH_ESC:              reject(ERR_UNTERM_ESC);
      PH_HEX1, PH_HEX2:    reject(ERR_TRUNC_U);
      PH_NEEDBS, PH_NEEDU: reject(ERR_MISSING_U);
      default:             dec_phase = PH_IDLE;
    endcase
  endfunction

  function automatic void predict_unescape(in_req_t r);
    step_res.delete();
    case (r.opcode)
      OP_TEXT: decode_text(r.text_byte);
      OP_END:  decode_end();
      OP_START: begin
        dec_phase = PH_STR;
        dec_hex_n = '0;
        dec_accum = '0;
        dec_high  = '0;
      end
      default: ;
    endcase
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
    utf8_expect_q = {utf8_expect_q, step_res};
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
    end else begin
      if (in_valid_i && !in_ready_o) backpressure_cycles++;
      if (in_valid_i && in_ready_o) begin
        predict_unescape(in_req_i);
        requests_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (byte_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_req_i   <= byte_stream_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    holdoff_cycles <= holdoff_on ? holdoff_cycles + 1 : 0;
  end

  // Result monitor and scoreboard
  always @(posedge clk_i or negedge rst_ni) begin : result_check
    out_rsp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        case (out_rsp_o.status)
          ST_DATA:  n_data++;
          ST_CLOSE: n_close++;
          default: begin
            n_err++;
            err_kinds_seen[out_rsp_o.error_code] = 1'b1;
          end
        endcase
        if (utf8_expect_q.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] unexpected result: data %02h status %0d err %0d last %0b",
                     $realtime, out_rsp_o.data_byte, out_rsp_o.status,
                     out_rsp_o.error_code, out_rsp_o.last);
          mismatches++;
        end else begin
          want = utf8_expect_q.pop_front();
          if (out_rsp_o.data_byte !== want.data_byte || out_rsp_o.status !== want.status ||
              out_rsp_o.error_code !== want.error_code || out_rsp_o.last !== want.last) begin
            if (mismatches < 10) begin
              $display("[%0t] mismatch: exp data %02h status %0d err %0d last %0b",
                       $realtime, want.data_byte, want.status, want.error_code, want.last);
              $display("          got data %02h status %0d err %0d last %0b",
                       out_rsp_o.data_byte, out_rsp_o.status, out_rsp_o.error_code,
                       out_rsp_o.last);
            end
            mismatches++;
          end
        end
      end
      if (holdoff_on) out_ready_i <= 1'b0;
      else out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus helpers
  task automatic push_req(opcode_e op, logic [7:0] b);
    in_req_t r;
    r.opcode    = op;
    r.text_byte = b;
    byte_stream_q = {byte_stream_q, r};
    items_queued++;
  endtask

  task automatic push_text(logic [7:0] b);
    push_req(OP_TEXT, b);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  task automatic push_hex(logic [15:0] v);
    for (int i = 3; i >= 0; i--) push_text(hex_char(v[i*4 +: 4]));
  endtask

  task automatic push_u(logic [15:0] v);
    push_text(CH_BSLASH);
    push_text(CH_U);
    push_hex(v);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'hFF, 8'h20)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] bad_escape_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_QUOTE || c == CH_BSLASH || c == "/" || c == "b" || c == "f" ||
           c == "n" || c == "r" || c == "t" || c == CH_U);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    if ($urandom_range(4) == 0) return CH_QUOTE;
    do c = 8'($urandom_range(255)); while (hex_nibble(c) >= 0);
    return c;
  endfunction

  function automatic logic [15:0] high_surr();
    return 16'hD800 + 16'($urandom_range(16'h3FF));
  endfunction

  function automatic logic [15:0] low_surr();
    return 16'hDC00 + 16'($urandom_range(16'h3FF));
  endfunction

  task automatic add_piece();
    logic [15:0] v;
    logic [7:0] esc_set [8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};
    case ($urandom_range(11))
      0, 1, 2, 3: push_text(plain_char());
      4: begin
        push_text(CH_BSLASH);
        push_text(esc_set[3'($urandom_range(7))]);
      end
      5: push_u(16'($urandom_range(16'h7F)));
      6: push_u(16'($urandom_range(16'h7FF, 16'h80)));
      7: begin
        do v = 16'($urandom_range(16'hFFFF, 16'h800));
        while (v >= 16'hD800 && v <= 16'hDFFF);
        push_u(v);
      end
      8, 9: begin
        push_u(high_surr());
        push_u(low_surr());
      end
      10: push_text($urandom_range(1) ? 8'h20 : 8'hFF);
      default: push_req(OP_RSVD, 8'($urandom_range(255)));
    endcase
  endtask

  task automatic add_fault();
    logic [15:0] v;
    logic [7:0] c;
    int k;
    case ($urandom_range(10))
      0: push_req(OP_END, 8'($urandom_range(255)));
      1: push_text(8'($urandom_range(8'h1F)));
      2: begin
        push_text(CH_BSLASH);
        push_text(bad_escape_char());
      end
      3: begin
        push_text(CH_BSLASH);
        push_req(OP_END, 8'h00);
      end
      4, 5: begin
        if ($urandom_range(1)) push_u(high_surr());
        push_text(CH_BSLASH);
        push_text(CH_U);
        k = $urandom_range(3);
        repeat (k) push_text(hex_char(4'($urandom_range(15))));
        if ($urandom_range(1)) push_text(non_hex_char());
        else push_req(OP_END, 8'h00);
      end
      6: push_u(low_surr());
      7: begin
        push_u(high_surr());
        if ($urandom_range(1)) begin
          do c = 8'($urandom_range(255)); while (c == CH_BSLASH);
          push_text(c);
        end else begin
          push_req(OP_END, 8'h00);
        end
      end
      8: begin
        push_u(high_surr());
        push_text(CH_BSLASH);
        if ($urandom_range(1)) begin
          do c = 8'($urandom_range(255)); while (c == CH_U);
          push_text(c);
        end else begin
          push_req(OP_END, 8'h00);
        end
      end
      9: begin
        push_u(high_surr());
        do v = 16'($urandom_range(16'hFFFF)); while (v >= 16'hDC00 && v <= 16'hDFFF);
        push_u(v);
      end
      default: begin
        // restart drops the open string silently
        push_req(OP_START, 8'($urandom_range(255)));
        add_piece();
        push_text(CH_QUOTE);
        return;
      end
    endcase
    // bytes arriving while idle are ignored
    repeat ($urandom_range(2)) push_text(8'($urandom_range(255)));
    if ($urandom_range(3) == 0) push_req(OP_END, 8'($urandom_range(255)));
  endtask

  task automatic add_string();
    int pieces;
    int fault_at;
    pieces   = $urandom_range(8);
    fault_at = ($urandom_range(99) < 30) ? $urandom_range(pieces) : -1;
    push_req(OP_START, 8'($urandom_range(255)));
    for (int k = 0; k <= pieces; k++) begin
      if (k == fault_at) begin
        add_fault();
        return;
      end
      if (k < pieces) add_piece();
    end
    push_text(CH_QUOTE);
  endtask

  task automatic run_random(int count);
    int first;
    first = items_queued;
    while (items_queued - first < count) begin
      if ($urandom_range(99) < 6)
        push_req(opcode_e'($urandom_range(3)), 8'($urandom_range(255)));
      else add_string();
    end
  endtask

  task automatic drain();
    while (byte_stream_q.size() != 0 || in_valid_i || utf8_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_flow(int send_pct, int recv_pct);
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: idle handling, extremes, escapes, largest pair, restart, control byte
    push_req(OP_END, 8'hFF);
    push_text("x");
    push_req(OP_RSVD, 8'h00);
    push_req(OP_START, 8'h00);
    push_text(8'hFF);
    push_text(8'h20);
    push_text(CH_BSLASH);
    push_text("n");
    push_u(16'hDBFF);
    push_u(16'hDFFF);
    push_text(CH_QUOTE);
    push_req(OP_START, 8'hFF);
    push_text(CH_BSLASH);
    push_text(CH_QUOTE);
    push_req(OP_START, 8'h55);
    push_text(8'h00);
    drain();

    set_flow(0, 0);
    run_random(90);
    drain();

    set_flow(46, 0);
    run_random(90);
    drain();

    // Sender pauses in the middle of a pair until the block has nothing left to give
    set_flow(0, 46);
    push_req(OP_START, 8'hAA);
    push_text("a");
    push_text(CH_BSLASH);
    push_text(CH_U);
    push_text("D");
    push_text("8");
    drain();
    push_text("0");
    push_text("1");
    push_u(16'hDC37);
    push_text(CH_QUOTE);
    run_random(80);
    drain();

    set_flow(35, 35);
    run_random(90);
    drain();

    // Output held off while requests keep coming, so the block has to stall its input
    @(negedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_on     = 1'b1;
    run_random(40);
    while (holdoff_cycles < HoldoffCycles) @(negedge clk_i);
    holdoff_on = 1'b0;
    drain();

    repeat (8) @(negedge clk_i);
    $display("Ran %0d requests through five flow-control phases, %0d input stall cycles seen.",
             requests_taken, backpressure_cycles);
    $display("Checked %0d results: %0d bytes, %0d closes, %0d errors of %0d kinds.",
             results_seen, n_data, n_close, n_err, $countones(err_kinds_seen));
    if (mismatches == 0 && utf8_expect_q.size() == 0) begin
      $display("json_string_unescape_utf8 regression: pass");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, utf8_expect_q.size());
      $display("json_string_unescape_utf8 regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d requests and %0d results outstanding",
             byte_stream_q.size(), utf8_expect_q.size());
    $display("json_string_unescape_utf8 regression: fail");
    $finish;
  end

endmodule
